FILE: rtl/core/sat_pkg.sv
// ----------------------------------------------------------------------------
// Station association table package
// Shared widths, status and operation codes, and control bundles.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int MAX_STATIONS_DEF = 16;

    localparam int ADDR_W      = 48;
    localparam int STATUS_W    = 3;
    localparam int AID_W       = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_store_ctl;

    typedef struct packed {
        logic clear;
        logic mark;
        logic start;
    } t_walk_ctl;

endpackage

FILE: rtl/core/station_association_table.sv
// ----------------------------------------------------------------------------
// Station association table
// Add and remove stations by MAC address and issue association IDs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the operation (add or remove), tdata
//   the 48-bit station address. m_axis carries one result per request:
//   status and association ID packed in tdata.
//   Each request scans every slot through the entry memory read port, one
//   slot per cycle, comparing addresses and marking used IDs. An add of a
//   new station then walks the ID bitmap one ID per cycle.
//   A remove, a duplicate add or a full table ends after the scan; a new add
//   ends after the walk. One request is in work at a time; s_axis_tready
//   is high only while the sequencer is idle.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its result is held in the sequencer until the
//   output register is free.
//   Reset empties the table (all valid flags cleared) and drops any
//   pending result. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module station_association_table #(
    parameter int MAX_STATIONS = sat_pkg::MAX_STATIONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sat_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // station_addr
    input  logic [sat_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sat_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // status, assoc_id
);

    localparam int SW  = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CW  = $clog2(MAX_STATIONS + 1);
    localparam int IDW = $clog2(MAX_STATIONS + 2);
    localparam int OW  = (IDW > sat_pkg::AID_W) ? IDW : sat_pkg::AID_W;
    localparam logic [CW-1:0] LastCnt = CW'(MAX_STATIONS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic                          r_op;
    logic [sat_pkg::ADDR_W-1:0]    r_addr;
    logic [CW-1:0]                 r_cnt;
    logic                          r_rd_v;
    logic [SW-1:0]                 r_rd_slot;
    logic                          r_hit;
    logic [SW-1:0]                 r_hit_slot;
    logic [IDW-1:0]                r_hit_id;
    logic                          r_free_ok;
    logic [SW-1:0]                 r_free_slot;
    logic [sat_pkg::STATUS_W-1:0]  r_status;
    logic [IDW-1:0]                r_id;
    logic                          r_m_valid;
    logic [sat_pkg::STATUS_W-1:0]  r_m_status;
    logic [IDW-1:0]                r_m_id;

    logic                          in_acc;
    logic                          scan_end;
    logic                          hit_now;
    logic                          out_load;
    logic                          rd_valid;
    logic [sat_pkg::ADDR_W-1:0]    rd_addr;
    logic [IDW-1:0]                rd_id;
    logic                          walk_done;
    logic [IDW-1:0]                walk_id;
    logic [OW-1:0]                 id_ext;
    logic [SW-1:0]                 wr_slot;
    sat_pkg::t_store_ctl           store_ctl;
    sat_pkg::t_walk_ctl            walk_ctl;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign scan_end = (r_state == S_SCAN) && (r_cnt == LastCnt) && !r_rd_v;
    assign hit_now  = r_rd_v && rd_valid && (rd_addr == r_addr);
    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state   = r_state;
        store_ctl = '0;
        walk_ctl  = '0;
        wr_slot   = r_hit_slot;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state        = S_SCAN;
                    walk_ctl.clear = 1'b1;
                end
            end
            S_SCAN: begin
                walk_ctl.mark = r_rd_v && rd_valid;
                if (scan_end) begin
                    if (r_op == sat_pkg::OP_REMOVE) begin
                        store_ctl.clr = r_hit;
                        n_state       = S_DONE;
                    end else if (r_hit || !r_free_ok) begin
                        n_state = S_DONE;
                    end else begin
                        walk_ctl.start = 1'b1;
                        n_state        = S_WALK;
                    end
                end
            end
            S_WALK: begin
                wr_slot = r_free_slot;
                if (walk_done) begin
                    store_ctl.wr = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_SCAN) && (r_cnt != LastCnt);

            if (in_acc) begin
                r_op      <= s_axis_tuser[0];
                r_addr    <= s_axis_tdata[sat_pkg::ADDR_W-1:0];
                r_cnt     <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end

            if ((r_state == S_SCAN) && (r_cnt != LastCnt)) begin
                r_cnt     <= r_cnt + 1'b1;
                r_rd_slot <= r_cnt[SW-1:0];
            end

            if (hit_now && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_rd_slot;
                r_hit_id   <= rd_id;
            end

            if (r_rd_v && !rd_valid && !r_free_ok) begin
                r_free_ok   <= 1'b1;
                r_free_slot <= r_rd_slot;
            end

            if (scan_end) begin
                if (r_op == sat_pkg::OP_REMOVE) begin
                    r_status <= r_hit ? sat_pkg::ST_REMOVED : sat_pkg::ST_NOT_FOUND;
                    r_id     <= '0;
                end else if (r_hit) begin
                    r_status <= sat_pkg::ST_PRESENT;
                    r_id     <= r_hit_id;
                end else begin
                    r_status <= sat_pkg::ST_FULL;
                    r_id     <= '0;
                end
            end

            if ((r_state == S_WALK) && walk_done) begin
                r_status <= sat_pkg::ST_ADDED;
                r_id     <= walk_id;
            end

            if (out_load) begin
                r_m_valid  <= 1'b1;
                r_m_status <= r_status;
                r_m_id     <= r_id;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    sat_store #(
        .MAX_STATIONS (MAX_STATIONS),
        .SW           (SW),
        .IDW          (IDW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_slot  (r_cnt[SW-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_addr  (rd_addr),
        .o_rd_id    (rd_id),
        .i_ctl      (store_ctl),
        .i_wr_slot  (wr_slot),
        .i_wr_addr  (r_addr),
        .i_wr_id    (walk_id)
    );

    sat_idmap #(
        .MAX_STATIONS (MAX_STATIONS),
        .IDW          (IDW)
    ) u_idmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (walk_ctl),
        .i_mark_id (rd_id),
        .o_done    (walk_done),
        .o_id      (walk_id)
    );

    assign id_ext        = OW'(r_m_id);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {id_ext[sat_pkg::AID_W-1:0], r_m_status};

endmodule

FILE: rtl/core/sat_store.sv
// ----------------------------------------------------------------------------
// Station store
// Entry memory (address and ID) with one registered read port, one write
// port, and per-slot valid flags cleared at reset.
// ----------------------------------------------------------------------------
module sat_store #(
    parameter int MAX_STATIONS = sat_pkg::MAX_STATIONS_DEF,
    parameter int SW           = 4,
    parameter int IDW          = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [SW-1:0]             i_rd_slot,
    output logic                      o_rd_valid,
    output logic [sat_pkg::ADDR_W-1:0] o_rd_addr,
    output logic [IDW-1:0]            o_rd_id,
    input  sat_pkg::t_store_ctl       i_ctl,
    input  logic [SW-1:0]             i_wr_slot,
    input  logic [sat_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [IDW-1:0]            i_wr_id
);

    localparam int EW = sat_pkg::ADDR_W + IDW;

    logic [EW-1:0]           r_mem [MAX_STATIONS];
    logic [MAX_STATIONS-1:0] r_valid;
    logic [EW-1:0]           r_q;
    logic                    r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_slot] <= {i_wr_addr, i_wr_id};
        end
        r_q <= r_mem[i_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= r_valid[i_rd_slot];
            if (i_ctl.wr) begin
                r_valid[i_wr_slot] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_valid[i_wr_slot] <= 1'b0;
            end
        end
    end

    assign o_rd_valid = r_q_valid;
    assign o_rd_addr  = r_q[EW-1:IDW];
    assign o_rd_id    = r_q[IDW-1:0];

endmodule

FILE: rtl/core/sat_idmap.sv
// ----------------------------------------------------------------------------
// ID map walker
// Collects the used IDs into a bitmap, then shifts it one ID per cycle to
// find the first gap, or the first free ID when the used IDs are contiguous.
// ----------------------------------------------------------------------------
module sat_idmap #(
    parameter int MAX_STATIONS = sat_pkg::MAX_STATIONS_DEF,
    parameter int IDW          = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sat_pkg::t_walk_ctl   i_ctl,
    input  logic [IDW-1:0]       i_mark_id,
    output logic                 o_done,
    output logic [IDW-1:0]       o_id
);

    localparam int NB = MAX_STATIONS + 2;
    localparam logic [IDW-1:0] LastId = IDW'(MAX_STATIONS);

    logic [NB-1:0]  r_map;
    logic [IDW-1:0] r_k;
    logic           r_busy;
    logic           r_done;
    logic           r_free_ok;
    logic [IDW-1:0] r_free_id;
    logic [IDW-1:0] r_id;
    logic           walk_end;

    assign walk_end = r_busy && ((!r_map[0] && r_map[1]) || (r_k == LastId));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= walk_end && !i_ctl.clear && !i_ctl.mark && !i_ctl.start;
            if (i_ctl.clear) begin
                r_map  <= '0;
                r_busy <= 1'b0;
            end else if (i_ctl.mark) begin
                r_map[i_mark_id] <= 1'b1;
            end else if (i_ctl.start) begin
                r_map     <= r_map >> 1;
                r_k       <= IDW'(1);
                r_busy    <= 1'b1;
                r_free_ok <= 1'b0;
            end else if (r_busy) begin
                if (!r_map[0] && r_map[1]) begin
                    r_id   <= r_k;
                    r_busy <= 1'b0;
                end else if (r_k == LastId) begin
                    r_id   <= r_free_ok ? r_free_id : r_k;
                    r_busy <= 1'b0;
                end else begin
                    if (!r_map[0] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_id <= r_k;
                    end
                    r_map <= r_map >> 1;
                    r_k   <= r_k + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_id   = r_id;

endmodule

FILE: rtl/core/sat_port_check.sv
// ----------------------------------------------------------------------------
// Station association table port checks
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sat_port_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sat_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [sat_pkg::STATUS_W-1:0] status;
    logic [sat_pkg::AID_W-1:0]    aid;

    assign status = m_axis_tdata[sat_pkg::STATUS_W-1:0];
    assign aid    = m_axis_tdata[sat_pkg::STATUS_W +: sat_pkg::AID_W];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (status <= sat_pkg::ST_NOT_FOUND))
        else $error("illegal status code");

    a_failed_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == sat_pkg::ST_FULL || status == sat_pkg::ST_REMOVED
            || status == sat_pkg::ST_NOT_FOUND)) |-> (aid == '0))
        else $error("nonzero ID on remove or failure");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item taken while previous item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind station_association_table sat_port_check u_port_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Station association table testbench
// Drives add and remove requests and predicts each status and association
// ID from a private copy of the table. Covers empty and full tables, ID gap
// reuse, duplicate adds, long output stalls and random request traffic.
// ----------------------------------------------------------------------------
module testbench;
    import sat_pkg::*;

    localparam int          N_SLOTS     = MAX_STATIONS_DEF;
    localparam int          POOL_SIZE   = 24;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_TAIL  = 2 * N_SLOTS + 8;
    localparam int unsigned CYCLE_LIMIT = 500_000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [AID_W-1:0]    aid;
    } assoc_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // station_addr
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status, assoc_id

    bit              sta_valid [N_SLOTS];
    logic [ADDR_W-1:0] sta_addr [N_SLOTS];
    int              sta_id    [N_SLOTS];

    assoc_result_t     pending_results[$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                error_count;
    int unsigned       cycle_count;
    int                hold_req_count;
    int                hold_ack_count;
    int                hold_count;
    int                sink_mode;
    int                sink_left;

    station_association_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic assoc_result_t predict_association(logic op, logic [ADDR_W-1:0] addr);
        assoc_result_t r;
        int            hit;
        int            free_slot;
        int            largest;
        int            new_id;
        logic [63:0]   used;
        hit       = -1;
        free_slot = -1;
        largest   = 0;
        used      = '0;
        r.status  = ST_NOT_FOUND;
        r.aid     = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (sta_valid[i]) begin
                if (hit < 0 && sta_addr[i] == addr) hit = i;
                used[sta_id[i]] = 1'b1;
                if (sta_id[i] > largest) largest = sta_id[i];
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (op == OP_REMOVE) begin
            if (hit >= 0) begin
                sta_valid[hit] = 1'b0;
                r.status       = ST_REMOVED;
            end
        end else if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.aid    = sta_id[hit][AID_W-1:0];
        end else if (free_slot < 0) begin
            r.status = ST_FULL;
        end else begin
            // lowest used ID with a free predecessor wins
            new_id = largest + 1;
            for (int k = 63; k >= 2; k--) begin
                if (used[k] && !used[k-1]) new_id = k - 1;
            end
            sta_valid[free_slot] = 1'b1;
            sta_addr[free_slot]  = addr;
            sta_id[free_slot]    = new_id;
            r.status             = ST_ADDED;
            r.aid                = new_id[AID_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] a;
        a[31:0]  = $urandom();
        a[47:32] = $urandom_range(0, 16'hFFFF);
        return a;
    endfunction

    task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_association(op, addr));
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_mode     <= 0;
            sink_left     <= 0;
            hold_count    <= 0;
        end else if (hold_ack_count != hold_req_count) begin
            m_axis_tready <= 1'b0;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_ack_count <= hold_req_count;
                hold_count     <= 0;
            end else begin
                hold_count <= hold_count + 1;
            end
        end else begin
            if (sink_left == 0) begin
                sink_mode <= $urandom_range(0, 3);
                sink_left <= $urandom_range(20, 120);
            end else begin
                sink_left <= sink_left - 1;
            end
            case (sink_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= cycle_count[2];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        assoc_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[STATUS_W-1:0] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tdata[STATUS_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[STATUS_W+AID_W-1:STATUS_W] !== want.aid) begin
                    $display("%0t: assoc_id mismatch, expected %0d, actual %0d",
                             $time, want.aid, m_axis_tdata[STATUS_W+AID_W-1:STATUS_W]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(OP_REMOVE, '0);
        send_request(OP_ADD, '0);
        send_request(OP_ADD, '0);
        send_request(OP_ADD, '1);
        send_request(OP_REMOVE, '1);
    endtask

    task automatic test_fill_and_reuse();
        for (int k = 1; k <= N_SLOTS - 1; k++) begin
            send_request(OP_ADD, 48'h5555_5555_5555 ^ (48'd1 << (3 * k)));
        end
        send_request(OP_ADD, 48'hAAAA_AAAA_AAAA);
        send_request(OP_ADD, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, 48'h5555_5555_5555 ^ (48'd1 << 21));
        send_request(OP_REMOVE, 48'h5555_5555_5555 ^ (48'd1 << 24));
        send_request(OP_ADD, 48'hAAAA_AAAA_AAAA);
        send_request(OP_ADD, 48'h8000_0000_0001);
        send_request(OP_REMOVE, '1);
    endtask

    task automatic test_receiver_hold();
        hold_req_count++;
        for (int n = 0; n < 8; n++) begin
            send_request(n[0] ? OP_REMOVE : OP_ADD, random_address());
        end
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        for (int n = 0; n < 5; n++) send_request(OP_ADD, random_address());
        wait_results_drained();
        for (int n = 0; n < 5; n++) send_request(OP_REMOVE, addr_pool[n]);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                burst_left;
        int                add_pct;
        int                phase_left;
        logic              op;
        logic [ADDR_W-1:0] addr;
        burst_left = 1;
        add_pct    = 70;
        phase_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (n % 200 == 0) begin
                addr_pool[0] = '0;
                addr_pool[1] = '1;
                for (int k = 2; k < POOL_SIZE; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        addr_pool[k] = addr_pool[k-1] ^ (48'd1 << $urandom_range(0, 47));
                    else
                        addr_pool[k] = random_address();
                end
            end
            if (phase_left == 0) begin
                add_pct    = $urandom_range(0, 1) ? 75 : 30;
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            op   = ($urandom_range(1, 100) <= add_pct) ? OP_ADD : OP_REMOVE;
            addr = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : random_address();
            send_request(op, addr);
            burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    burst_left = $urandom_range(20, 50);
                end else begin
                    idle_sender($urandom_range(1, 15));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = random_address();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_and_reuse();
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic(860);

        wait_results_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
